// ===== src/deq_pkg.sv =====
// shared types, codes and defaults of the double-ended queue
package deq_pkg;

	// default number of entries
	localparam int DEFAULT_DEPTH = 16;

	// operation codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DUMP       = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       push_front;
		logic       push_back;
		logic       pop_front;
		logic       pop_back;
		logic       dump_start;
		logic       dump_next;
		logic       load_res;
		logic [1:0] res_status;
		logic       emit;
		logic       emit_last;
	} deq_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic full;
		logic dump_last;
		logic out_free;
	} deq_sts_t;

endpackage

// ===== src/deq_ctrl.sv =====
// controller state machine of the double-ended queue
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  deq_pkg::deq_sts_t sts,
	output deq_pkg::deq_cmd_t cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EMIT = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       single_q;
	logic       single_d;
	logic       accept;

	// items are taken only when idle and the output register can take a result
	assign in_stall = (state_q != S_IDLE) || !sts.out_free;
	assign accept   = in_valid && !in_stall;

	// next state and command decode
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		single_d = single_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (operation)
						deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
							cmd.load_res = 1'b1;
							if (sts.full) begin
								cmd.res_status = deq_pkg::ST_FULL;
							end else begin
								cmd.res_status = deq_pkg::ST_OK;
								cmd.push_front = (operation == deq_pkg::OP_PUSH_FRONT);
								cmd.push_back  = (operation == deq_pkg::OP_PUSH_BACK);
							end
						end
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
							if (sts.empty) begin
								cmd.load_res   = 1'b1;
								cmd.res_status = deq_pkg::ST_EMPTY;
							end else begin
								cmd.pop_front = (operation == deq_pkg::OP_POP_FRONT);
								cmd.pop_back  = (operation == deq_pkg::OP_POP_BACK);
								state_d       = S_EMIT;
								single_d      = 1'b1;
							end
						end
						deq_pkg::OP_DUMP: begin
							if (sts.empty) begin
								cmd.load_res   = 1'b1;
								cmd.res_status = deq_pkg::ST_EMPTY;
							end else begin
								cmd.dump_start = 1'b1;
								state_d        = S_EMIT;
								single_d       = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = single_q || sts.dump_last;
					if (single_q || sts.dump_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.dump_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			single_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			single_q <= single_d;
		end
	end

	// no queue update while results are being streamed
	a_no_update_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> !(cmd.push_front || cmd.push_back ||
		cmd.pop_front || cmd.pop_back || cmd.dump_start))
		else $error("queue update while streaming results");

	// a result is only loaded when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.load_res) |-> sts.out_free)
		else $error("result loaded into busy output register");

	// the last streamed result returns the controller to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after last result");

endmodule

// ===== src/deq_datapath.sv =====
// ring buffer storage, pointers and output register of the double-ended queue
module deq_datapath #(
	parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] value,
	input  deq_pkg::deq_cmd_t  cmd,
	output deq_pkg::deq_sts_t  sts,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_res,
	output logic [1:0]         status,
	output logic               last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_q;
	logic [AW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      offset_q;
	logic               out_valid_q;
	logic signed [31:0] value_res_q;
	logic [1:0]         status_q;
	logic               last_q;

	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW-1:0] count_lo;
	logic [AW-1:0] count_m1;
	logic [AW-1:0] offset_inc;

	// front index plus an offset, wrapped into the ring
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	// pointer arithmetic
	assign count_lo   = count_q[AW-1:0];
	assign count_m1   = count_lo - AW'(1);
	assign offset_inc = offset_q + AW'(1);
	assign front_dec  = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
	assign front_inc  = slot_of(front_q, AW'(1));

	// write and read addresses
	assign wr_addr = cmd.push_front ? front_dec : slot_of(front_q, count_lo);
	always_comb begin
		priority if (cmd.pop_back) begin
			rd_addr = slot_of(front_q, count_m1);
		end else if (cmd.dump_next) begin
			rd_addr = slot_of(front_q, offset_inc);
		end else begin
			rd_addr = front_q;
		end
	end
	assign rd_en = cmd.pop_front || cmd.pop_back || cmd.dump_start || cmd.dump_next;

	// entry storage with registered read
	always_ff @(posedge clk) begin
		if (cmd.push_front || cmd.push_back) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// front index, count and dump offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			offset_q <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			if (cmd.push_front || cmd.push_back) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.dump_start) begin
				offset_q <= '0;
			end else if (cmd.dump_next) begin
				offset_q <= offset_inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			value_res_q <= '0;
			status_q    <= cmd.res_status;
			last_q      <= 1'b1;
		end else if (cmd.emit) begin
			value_res_q <= rd_data_q;
			status_q    <= deq_pkg::ST_OK;
			last_q      <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign status    = status_q;
	assign last      = last_q;

	// status toward the controller
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.dump_last = ((CW'(offset_q) + CW'(1)) == count_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// occupancy never exceeds the ring size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above depth");

	// front index stays inside the ring
	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, front_q} < DEPTH_W)
		else $error("front index outside ring");

	// a push is never issued into a full queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |-> !sts.full)
		else $error("push into full queue");

	// a successful push grows the queue by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the queue");

endmodule

// ===== src/double_ended_queue_core.sv =====
// top level of the double-ended queue
//
// Bounded double-ended queue of signed 32-bit values in a ring buffer of
// DEPTH entries. The input channel (in_valid, in_stall, operation, value)
// takes one operation per item: push front, push back, pop front, pop back
// or dump. Codes 5 to 7 are accepted and dropped without a result.
// The output channel (out_valid, out_stall, value_res, status, last) gives
// one result per push or pop, and one result per stored entry for a dump,
// front to back, with last set on the final one. Empty pops and dumps give
// status empty, a push to a full queue gives status full and changes nothing.
// Pushes and refused operations produce their result in the cycle after the
// item is taken; pops and dumps first read the entry memory into a read
// register, then move it into the output register, one result a cycle while
// the receiver does not stall. The single read port of the entry memory sets
// that pace. in_stall stays high while a pop or dump result is pending, so
// no new item is taken before the last result of a pop or dump is loaded.
// When the receiver stalls, the result is held in the output register and
// streaming pauses. Reset empties the queue at once; no clearing pass.
module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_res,
	output logic [1:0]         status,
	output logic               last
);

	deq_pkg::deq_cmd_t cmd;
	deq_pkg::deq_sts_t sts;

	// operation sequencing
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, pointers and result register
	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_res (value_res),
		.status    (status),
		.last      (last)
	);

endmodule
